// ----- rtl/ctpll_pkg.sv -----
// ----------------------------------------------------------------------------
// ctpll_pkg: shared constants and helpers for the carrier tracking PLL
// CORDIC arctangent table, register indexes, reset values and widths
// ----------------------------------------------------------------------------
`default_nettype none

package ctpll_pkg;

  // number of CORDIC iterations for rotation and for vectoring (8 to 24)
  localparam int CORDIC_STAGES = 16;
  localparam int ITER_W        = $clog2(CORDIC_STAGES);
  localparam int ATAN_LEN      = 24;
  localparam int ATAN_IDX_W    = 5;

  // datapath widths
  localparam int XY_W   = 27;
  localparam int MULB_W = 31;
  localparam int PROD_W = XY_W + MULB_W;
  localparam int GAIN_W = 24;
  localparam int ROT_W  = 17;
  localparam int ERR_W  = 16;

  // 1/K of the CORDIC in Q30
  localparam logic signed [MULB_W-1:0] KINV_Q30 = 31'sd652032875;
  localparam logic signed [ROT_W-1:0]  ROT_MAX  = 17'sd46341;

  // register indexes
  localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [1:0] REG_INTEG_GAIN = 2'd1;

  // register reset values
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 24'd1115384;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 24'd5903;

  // arctangent of 2^-i in turns scaled by 2^32
  function automatic logic [31:0] atan_turns(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // round the 1/K product half up to the sample scale and saturate
  function automatic logic signed [ROT_W-1:0] descale(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    logic signed [19:0]       r;
    logic signed [ROT_W-1:0]  o;
    s = p + (PROD_W'(1) <<< 37);
    r = s[PROD_W-1:38];
    if (r > 20'(ROT_MAX)) begin
      o = ROT_MAX;
    end else if (r < -20'(ROT_MAX)) begin
      o = -ROT_MAX;
    end else begin
      o = r[ROT_W-1:0];
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/carrier_tracking_pll_top.sv -----
// ----------------------------------------------------------------------------
// carrier_tracking_pll_top: second-order carrier tracking PLL
// derotation by the NCO, CORDIC atan2 phase detector and PI loop filter
// ----------------------------------------------------------------------------
// One complex sample per transfer. A single CORDIC unit first rotates the
// sample by minus the NCO phase, a single 27x31 multiplier scales by 1/K,
// then the same CORDIC measures the angle of the derotated sample, and the
// multiplier forms the proportional term and the integrator increment.
// When the derotated sample is zero the vectoring pass is skipped and the
// phase error is taken as zero. s_tready is low while an item is in work.
// The result sits in an output register, so the next sample is taken while
// the last result is still waiting. Configuration writes are taken any
// time but belong in idle periods.
`default_nettype none

module carrier_tracking_pll_top
  import ctpll_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  // input sample stream
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [31:0]   s_tdata,   // i_sample[15:0], q_sample[31:16]
  input  wire logic          s_tlast,   // slice_last
  // result stream
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [119:0]       m_tdata,   // rot_i[16:0], rot_q[33:17], phase_error[49:34],
                                        // prop_term[81:50], freq_estimate[113:82], zero
  output logic               m_tlast,   // slice_last_out
  // configuration
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_addr,
  input  wire logic [23:0]   cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_ROT, S_MUL_X, S_MUL_Y, S_DESC_Y, S_VEC_INIT, S_VEC,
    S_ERR, S_MUL_P, S_MUL_I, S_UPD, S_PHASE
  } state_t;

  state_t state;

  logic [GAIN_W-1:0]        prop_gain;
  logic [GAIN_W-1:0]        integ_gain;
  logic [31:0]              nco_phase;
  logic signed [31:0]       freq_accum;

  logic signed [XY_W-1:0]   x;
  logic signed [XY_W-1:0]   y;
  logic [31:0]              z;
  logic [ITER_W-1:0]        iter;
  logic signed [PROD_W-1:0] prod;
  logic signed [ROT_W-1:0]  rot_i;
  logic signed [ROT_W-1:0]  rot_q;
  logic signed [ERR_W-1:0]  err;
  logic signed [31:0]       prop;
  logic                     last;

  logic signed [ROT_W-1:0]  o_rot_i;
  logic signed [ROT_W-1:0]  o_rot_q;
  logic signed [ERR_W-1:0]  o_err;
  logic signed [31:0]       o_prop;
  logic signed [31:0]       o_freq;
  logic                     o_last;

  // input sample, prescaled by 2^8
  logic signed [XY_W-1:0]   in_x;
  logic signed [XY_W-1:0]   in_y;
  logic [31:0]              in_ang;
  logic                     in_flip;

  assign in_x    = {{3{s_tdata[15]}}, s_tdata[15:0], 8'b0};
  assign in_y    = {{3{s_tdata[31]}}, s_tdata[31:16], 8'b0};
  assign in_ang  = 32'd0 - nco_phase;
  assign in_flip = (in_ang > 32'h4000_0000) && (in_ang < 32'hC000_0000);

  // derotated sample, prescaled for the vectoring pass
  logic signed [XY_W-1:0]   vec_x;
  logic signed [XY_W-1:0]   vec_y;

  assign vec_x = {{2{rot_i[ROT_W-1]}}, rot_i, 8'b0};
  assign vec_y = {{2{rot_q[ROT_W-1]}}, rot_q, 8'b0};

  // shared cordic iteration
  logic                     dir_pos;
  logic signed [XY_W-1:0]   x_sh;
  logic signed [XY_W-1:0]   y_sh;
  logic [31:0]              atan_v;
  logic signed [XY_W-1:0]   x_next;
  logic signed [XY_W-1:0]   y_next;
  logic [31:0]              z_next;
  logic                     iter_last;

  always_comb begin
    dir_pos = (state == S_ROT) ? !z[31] : y[XY_W-1];
    x_sh    = x >>> iter;
    y_sh    = y >>> iter;
    atan_v  = atan_turns(ATAN_IDX_W'(iter));
    if (dir_pos) begin
      x_next = x - y_sh;
      y_next = y + x_sh;
      z_next = z - atan_v;
    end else begin
      x_next = x + y_sh;
      y_next = y - x_sh;
      z_next = z + atan_v;
    end
  end

  assign iter_last = (iter == ITER_W'(CORDIC_STAGES - 1));

  // shared multiplier operand select
  logic signed [XY_W-1:0]   mul_a;
  logic signed [MULB_W-1:0] mul_b;

  always_comb begin
    case (state)
      S_MUL_X: begin
        mul_a = x;
        mul_b = KINV_Q30;
      end
      S_MUL_Y: begin
        mul_a = y;
        mul_b = KINV_Q30;
      end
      S_MUL_P: begin
        mul_a = XY_W'(err);
        mul_b = {7'b0, prop_gain};
      end
      default: begin
        mul_a = XY_W'(err);
        mul_b = {7'b0, integ_gain};
      end
    endcase
  end

  // scaled product terms and saturating integrator
  logic signed [31:0]       prod_sh;
  logic signed [32:0]       acc_sum;
  logic signed [31:0]       acc_sat;
  logic [31:0]              err_round;

  assign prod_sh   = prod[39:8];
  assign acc_sum   = 33'(freq_accum) + 33'(prod_sh);
  assign err_round = z + 32'h0000_8000;

  always_comb begin
    if (acc_sum[32] != acc_sum[31]) begin
      acc_sat = acc_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      acc_sat = acc_sum[31:0];
    end
  end

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // multiplier output register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // sequencer, loop state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      prop_gain  <= PROP_GAIN_RST;
      integ_gain <= INTEG_GAIN_RST;
      nco_phase  <= '0;
      freq_accum <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_PROP_GAIN:  prop_gain  <= cfg_data;
          REG_INTEG_GAIN: integ_gain <= cfg_data;
          default: ;
        endcase
      end

      // result valid: set on load, cleared on transfer
      if (state == S_PHASE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            x     <= in_flip ? -in_x : in_x;
            y     <= in_flip ? -in_y : in_y;
            z     <= in_flip ? in_ang + 32'h8000_0000 : in_ang;
            iter  <= '0;
            last  <= s_tlast;
            state <= S_ROT;
          end
        end
        S_ROT: begin
          x    <= x_next;
          y    <= y_next;
          z    <= z_next;
          iter <= iter + ITER_W'(1);
          if (iter_last) begin
            state <= S_MUL_X;
          end
        end
        S_MUL_X: state <= S_MUL_Y;
        S_MUL_Y: begin
          rot_i <= descale(prod);
          state <= S_DESC_Y;
        end
        S_DESC_Y: begin
          rot_q <= descale(prod);
          state <= S_VEC_INIT;
        end
        S_VEC_INIT: begin
          if (rot_i == '0 && rot_q == '0) begin
            err   <= '0;
            state <= S_MUL_P;
          end else begin
            x     <= rot_i[ROT_W-1] ? -vec_x : vec_x;
            y     <= rot_i[ROT_W-1] ? -vec_y : vec_y;
            z     <= rot_i[ROT_W-1] ? 32'h8000_0000 : 32'h0;
            iter  <= '0;
            state <= S_VEC;
          end
        end
        S_VEC: begin
          x    <= x_next;
          y    <= y_next;
          z    <= z_next;
          iter <= iter + ITER_W'(1);
          if (iter_last) begin
            state <= S_ERR;
          end
        end
        S_ERR: begin
          err   <= err_round[31:16];
          state <= S_MUL_P;
        end
        S_MUL_P: state <= S_MUL_I;
        S_MUL_I: begin
          prop  <= prod_sh;
          state <= S_UPD;
        end
        S_UPD: begin
          freq_accum <= acc_sat;
          state      <= S_PHASE;
        end
        S_PHASE: begin
          // hold here until the result register is free
          if (out_free) begin
            nco_phase <= nco_phase + prop + freq_accum;
            o_rot_i   <= rot_i;
            o_rot_q   <= rot_q;
            o_err     <= err;
            o_prop    <= prop;
            o_freq    <= freq_accum;
            o_last    <= last;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {6'b0, o_freq, o_prop, o_err, o_rot_q, o_rot_i};
  assign m_tlast  = o_last;

  // a transfer in always starts a busy period
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a sample is in work");

  // a result is only loaded into a free output register
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && state == S_PHASE |=> state == S_PHASE)
    else $error("result overwritten before transfer");

  // derotated values stay within the saturation limits
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (o_rot_i <= ROT_MAX) && (o_rot_i >= -ROT_MAX)
              && (o_rot_q <= ROT_MAX) && (o_rot_q >= -ROT_MAX))
    else $error("derotated sample out of range");

  // while idle the waiting result reports the current integrator
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && state == S_IDLE |-> o_freq == freq_accum)
    else $error("frequency estimate differs from integrator");

endmodule

`default_nettype wire
